>>> rtl/core/wsti_pkg.sv
`timescale 1ns / 1ps
// Package for the wide string to int64 parser: parse phases, character codes,
// saturation limits and the digit decode function. No dependencies.
package wsti_pkg;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_PREFIX = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    localparam int unsigned MAX_LENGTH_DEF = 32'd65535;

    localparam int CHAR_W  = 21;
    localparam int BASE_W  = 6;
    localparam int VALUE_W = 64;
    localparam int END_W   = 16;
    localparam int DIGIT_W = 7;

    localparam logic [CHAR_W-1:0] CH_SPACE = 21'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 21'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 21'd13;
    localparam logic [CHAR_W-1:0] CH_MINUS = 21'd45;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 21'd43;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 21'd48;
    localparam logic [CHAR_W-1:0] CH_LOW_X = 21'd120;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 21'd88;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    localparam logic [VALUE_W-1:0] SAT_POS_VAL = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] SAT_NEG_VAL = 64'h8000_0000_0000_0000;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

    typedef logic [DIGIT_W-1:0] t_digit;

    function automatic t_digit digit_value(input logic [CHAR_W-1:0] c);
        t_digit d;
        d = DIGIT_NONE;
        if (c >= 21'd48 && c <= 21'd57) begin
            d = DIGIT_W'(c - 21'd48);
        end else if (c >= 21'd65 && c <= 21'd90) begin
            d = DIGIT_W'(c - 21'd55);
        end else if (c >= 21'd97 && c <= 21'd122) begin
            d = DIGIT_W'(c - 21'd87);
        end
        return d;
    endfunction

endpackage

>>> rtl/core/wsti_mac.sv
`timescale 1ns / 1ps
// Saturating multiply-add of one digit into the 64-bit magnitude.
// Depends on wsti_pkg.
module wsti_mac (
    input  logic [wsti_pkg::VALUE_W-1:0] i_acc,
    input  logic [wsti_pkg::BASE_W-1:0]  i_base,
    input  logic [wsti_pkg::BASE_W-1:0]  i_digit,
    input  logic                         i_negative,
    input  logic                         i_overflowed,
    output logic [wsti_pkg::VALUE_W-1:0] o_acc,
    output logic                         o_overflowed
);

    localparam int PROD_W = wsti_pkg::VALUE_W + wsti_pkg::BASE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_limit;
    logic              w_over;

    assign w_prod  = PROD_W'(i_acc) * PROD_W'(i_base);
    assign w_sum   = SUM_W'(w_prod) + SUM_W'(i_digit);
    // magnitude limit: 2^63 when negative, 2^63-1 otherwise
    assign w_limit = i_negative ? SUM_W'(wsti_pkg::SAT_NEG_VAL) : SUM_W'(wsti_pkg::SAT_POS_VAL);
    assign w_over  = i_overflowed || (w_sum > w_limit);

    assign o_overflowed = w_over;
    assign o_acc        = w_over ? i_acc : w_sum[wsti_pkg::VALUE_W-1:0];

endmodule

>>> rtl/core/wide_string_to_int64_parser.sv
`timescale 1ns / 1ps
// Wide-character string to signed 64-bit integer parser, top level.
// Depends on wsti_pkg and wsti_mac.
//
//  channel  | dir | beat content
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | tdata: char_code[20:0]; tuser: string_start
//  m_axis   | out | tdata: value[63:0], end_offset[79:64]; tuser: out_of_range
//  cfg      | in  | i_cfg_data: number_base[5:0]
//
// One character per cycle unless a stall on m_axis holds the input.
// The input register and the output register each hold one beat; the per-character
// step (one 64x6 multiply-add and limit compare) sits between them.
// A stall on m_axis backs up into s_axis only once both registers are full.
// Reset (synchronous, active low) clears the parse state and sets number_base to 10.
module wide_string_to_int64_parser #(
    parameter int unsigned MAX_LENGTH = wsti_pkg::MAX_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[20:0], zero pad
    input  logic [0:0]  s_axis_tuser,   // string_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // value[63:0], end_offset[79:64]
    output logic [0:0]  m_axis_tuser,   // out_of_range
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [wsti_pkg::BASE_W-1:0] i_cfg_data
);

    localparam int POS_W = $clog2(64'(MAX_LENGTH) + 64'd1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);
    localparam int VW = wsti_pkg::VALUE_W;
    localparam int BW = wsti_pkg::BASE_W;
    localparam int CW = wsti_pkg::CHAR_W;

    // configuration
    logic [BW-1:0] r_number_base;

    // input register
    logic          r_in_valid;
    logic [CW-1:0] r_in_char;
    logic          r_in_start;

    // parse state
    wsti_pkg::t_phase r_phase, n_phase;
    logic             r_negative, n_negative;
    logic [VW-1:0]    r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic             r_seen, n_seen;
    logic [BW-1:0]    r_base, n_base;
    logic [POS_W-1:0] r_pos, n_pos;

    // output register
    logic          r_out_valid;
    logic [VW-1:0] r_out_value;
    logic          r_out_oor;
    logic [15:0]   r_out_end;

    wsti_pkg::t_phase e_phase;
    logic             e_negative;
    logic [VW-1:0]    e_acc;
    logic             e_ovf;
    logic             e_seen;
    logic [BW-1:0]    e_base;
    logic [POS_W-1:0] e_pos;

    logic          w_out_free;
    logic          w_step;
    logic          w_ws;
    wsti_pkg::t_digit w_digit;
    logic          w_begin;
    logic          w_take;
    logic          w_prefix_acc;
    logic [BW-1:0] w_take_base;
    logic [BW-1:0] w_mac_base;
    logic          w_emit;
    logic [POS_W-1:0] w_end;
    logic [POS_W+15:0] w_end_ext;
    logic [VW-1:0] w_mac_acc;
    logic          w_mac_ovf;
    logic [VW-1:0] w_res_value;
    logic          w_res_oor;
    logic [15:0]   w_res_end;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign o_cfg_ready   = 1'b1;

    // string start discards the parse in progress
    assign e_phase    = r_in_start ? wsti_pkg::PH_SPACE : r_phase;
    assign e_negative = r_in_start ? 1'b0 : r_negative;
    assign e_acc      = r_in_start ? '0 : r_acc;
    assign e_ovf      = r_in_start ? 1'b0 : r_ovf;
    assign e_seen     = r_in_start ? 1'b0 : r_seen;
    assign e_base     = r_in_start ? wsti_pkg::BASE_DEC : r_base;
    assign e_pos      = r_in_start ? '0 : r_pos;

    assign w_digit = wsti_pkg::digit_value(r_in_char);
    assign w_ws    = (r_in_char == wsti_pkg::CH_SPACE) ||
                     (r_in_char >= wsti_pkg::CH_TAB && r_in_char <= wsti_pkg::CH_CR);

    assign w_mac_base = w_prefix_acc ? wsti_pkg::BASE_HEX : w_take_base;

    wsti_mac u_mac (
        .i_acc        (e_acc),
        .i_base       (w_mac_base),
        .i_digit      (w_digit[BW-1:0]),
        .i_negative   (e_negative),
        .i_overflowed (e_ovf),
        .o_acc        (w_mac_acc),
        .o_overflowed (w_mac_ovf)
    );

    always_comb begin
        n_phase      = e_phase;
        n_negative   = e_negative;
        n_acc        = e_acc;
        n_ovf        = e_ovf;
        n_seen       = e_seen;
        n_base       = e_base;
        n_pos        = (e_pos < POS_MAX) ? e_pos + POS_W'(1) : e_pos;
        w_begin      = 1'b0;
        w_take       = 1'b0;
        w_prefix_acc = 1'b0;
        w_take_base  = e_base;
        w_emit       = 1'b0;
        w_end        = e_pos;

        case (e_phase)
            wsti_pkg::PH_SPACE: begin
                if (w_ws) begin
                    n_phase = wsti_pkg::PH_SPACE;
                end else if (r_in_char == wsti_pkg::CH_MINUS) begin
                    n_negative = 1'b1;
                    n_phase    = wsti_pkg::PH_SIGNED;
                end else if (r_in_char == wsti_pkg::CH_PLUS) begin
                    n_phase = wsti_pkg::PH_SIGNED;
                end else begin
                    w_begin = 1'b1;
                end
            end
            wsti_pkg::PH_SIGNED: begin
                w_begin = 1'b1;
            end
            wsti_pkg::PH_ZERO: begin
                if (r_in_char == wsti_pkg::CH_LOW_X || r_in_char == wsti_pkg::CH_UP_X) begin
                    n_phase = wsti_pkg::PH_PREFIX;
                end else begin
                    w_take      = 1'b1;
                    w_take_base = (e_base == wsti_pkg::BASE_AUTO) ? wsti_pkg::BASE_OCT : e_base;
                end
            end
            wsti_pkg::PH_PREFIX: begin
                if (w_digit < wsti_pkg::DIGIT_W'(wsti_pkg::BASE_HEX)) begin
                    w_prefix_acc = 1'b1;
                    n_base       = wsti_pkg::BASE_HEX;
                    n_acc        = w_mac_acc;
                    n_ovf        = w_mac_ovf;
                    n_seen       = 1'b1;
                    n_phase      = wsti_pkg::PH_DIGITS;
                end else begin
                    // bare prefix: the number ends at the zero
                    w_emit  = 1'b1;
                    w_end   = (e_pos != '0) ? e_pos - POS_W'(1) : '0;
                    n_phase = wsti_pkg::PH_DONE;
                end
            end
            wsti_pkg::PH_DIGITS: begin
                w_take = 1'b1;
            end
            default: begin
                n_phase = e_phase;
            end
        endcase

        if (w_begin) begin
            n_base = r_number_base;
            if ((r_number_base == wsti_pkg::BASE_AUTO || r_number_base == wsti_pkg::BASE_HEX) &&
                r_in_char == wsti_pkg::CH_ZERO) begin
                n_seen  = 1'b1;
                n_acc   = '0;
                n_phase = wsti_pkg::PH_ZERO;
            end else begin
                w_take      = 1'b1;
                w_take_base = (r_number_base == wsti_pkg::BASE_AUTO) ? wsti_pkg::BASE_DEC
                                                                     : r_number_base;
            end
        end

        if (w_take) begin
            n_base = w_take_base;
            if (w_take_base < wsti_pkg::BASE_MIN || w_take_base > wsti_pkg::BASE_MAX ||
                w_digit >= wsti_pkg::DIGIT_W'(w_take_base)) begin
                w_emit  = 1'b1;
                w_end   = e_pos;
                n_phase = wsti_pkg::PH_DONE;
            end else begin
                n_acc   = w_mac_acc;
                n_ovf   = w_mac_ovf;
                n_seen  = 1'b1;
                n_phase = wsti_pkg::PH_DIGITS;
            end
        end
    end

    assign w_end_ext = {16'b0, w_end};

    always_comb begin
        w_res_value = '0;
        w_res_oor   = 1'b0;
        w_res_end   = '0;
        if (e_seen) begin
            if (e_ovf) begin
                w_res_value = e_negative ? wsti_pkg::SAT_NEG_VAL : wsti_pkg::SAT_POS_VAL;
            end else begin
                w_res_value = e_negative ? (VW'(0) - e_acc) : e_acc;
            end
            w_res_oor = e_ovf;
            w_res_end = w_end_ext[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= wsti_pkg::BASE_DEC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_number_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char  <= s_axis_tdata[CW-1:0];
            r_in_start <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= wsti_pkg::PH_SPACE;
            r_negative <= 1'b0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_seen     <= 1'b0;
            r_base     <= wsti_pkg::BASE_DEC;
            r_pos      <= '0;
        end else if (w_step) begin
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_seen     <= n_seen;
            r_base     <= n_base;
            r_pos      <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_value <= w_res_value;
            r_out_oor   <= w_res_oor;
            r_out_end   <= w_res_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_end, r_out_value};
    assign m_axis_tuser  = r_out_oor;

endmodule

>>> rtl/core/wsti_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the wide string to int64 parser, bound to the top level.
// Depends on wsti_pkg and wide_string_to_int64_parser.
module wsti_checker #(
    parameter int unsigned MAX_LENGTH = wsti_pkg::MAX_LENGTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    localparam bit END_FITS = (64'(MAX_LENGTH) <= 64'd65535);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_oor_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[63:0] == wsti_pkg::SAT_POS_VAL ||
            m_axis_tdata[63:0] == wsti_pkg::SAT_NEG_VAL)
        else $error("out of range result not saturated");

    a_no_digit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        END_FITS && m_axis_tvalid && m_axis_tdata[79:64] == 16'd0 |->
            m_axis_tdata[63:0] == 64'd0 && !m_axis_tuser[0])
        else $error("result without digits is not zero");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule

bind wide_string_to_int64_parser wsti_checker #(.MAX_LENGTH(MAX_LENGTH)) u_wsti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/wide_string_to_int64_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for wide_string_to_int64_parser: a directed table, then random
// strings over many bases, checked beat by beat against a built-in strtoll-style model.
// Depends on wsti_pkg and the parser RTL.
module wide_string_to_int64_parser_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RAND_ITEMS   = 1000;
    localparam int PHASE_ITEMS  = 130;
    localparam int LONG_RUN     = 200;

    localparam logic [wsti_pkg::CHAR_W-1:0] CH_NUL    = 21'd0;
    localparam logic [wsti_pkg::CHAR_W-1:0] CH_BANG   = 21'd33;
    localparam logic [wsti_pkg::CHAR_W-1:0] CH_UP_A   = 21'd65;
    localparam logic [wsti_pkg::CHAR_W-1:0] CH_LOW_A  = 21'd97;
    localparam logic [wsti_pkg::CHAR_W-1:0] CH_TOP    = 21'h10FFFF;
    localparam logic [wsti_pkg::BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [wsti_pkg::BASE_W-1:0] BASE_BAD  = 6'd63;

    typedef struct packed {
        logic [wsti_pkg::VALUE_W-1:0] value;
        logic                         oor;
        logic [wsti_pkg::END_W-1:0]   end_off;
    } t_int_result;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_CHARS
    } t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [wsti_pkg::CHAR_W-1:0] code;
        logic                        start;
        int                          reps;
        logic                        typed;
        t_int_result                 want;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_BUSY,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // char_code[20:0], zero pad
    logic [0:0]  s_axis_tuser;     // string_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;     // value[63:0], end_offset[79:64]
    logic [0:0]  m_axis_tuser;     // out_of_range
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [wsti_pkg::BASE_W-1:0] i_cfg_data;

    wide_string_to_int64_parser #(
        .MAX_LENGTH(wsti_pkg::MAX_LENGTH_DEF)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // parser model state
    logic [wsti_pkg::BASE_W-1:0]  cfg_base;
    wsti_pkg::t_phase             ps_phase;
    logic                         ps_neg;
    logic [wsti_pkg::VALUE_W-1:0] ps_acc;
    logic                         ps_ovf;
    logic                         ps_seen;
    logic [wsti_pkg::BASE_W-1:0]  ps_base;
    logic [wsti_pkg::END_W-1:0]   ps_pos;
    logic                         step_emitted;
    t_int_result                  step_result;

    t_int_result pending_results[$];
    t_dir_row    dir_rows[$];
    int          n_errors;
    int          chars_sent;
    int          burst_left;
    int          quiet_cycles;
    int          hold_asks;
    int          hold_done;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [6:0] char_digit(input logic [wsti_pkg::CHAR_W-1:0] c);
        if (c >= wsti_pkg::CH_ZERO && c <= wsti_pkg::CH_ZERO + 9)
            return 7'(c - wsti_pkg::CH_ZERO);
        if (c >= CH_UP_A && c <= CH_UP_A + 25) return 7'(c - CH_UP_A + 10);
        if (c >= CH_LOW_A && c <= CH_LOW_A + 25) return 7'(c - CH_LOW_A + 10);
        return 7'd99;
    endfunction

    task automatic clear_parse();
        ps_phase = wsti_pkg::PH_SPACE;
        ps_neg   = 1'b0;
        ps_acc   = '0;
        ps_ovf   = 1'b0;
        ps_seen  = 1'b0;
        ps_base  = wsti_pkg::BASE_DEC;
        ps_pos   = '0;
    endtask

    task automatic add_digit(input logic [6:0] d);
        logic [wsti_pkg::VALUE_W-1:0] lim;
        lim = ps_neg ? wsti_pkg::SAT_NEG_VAL : wsti_pkg::SAT_POS_VAL;
        if (ps_ovf || ps_acc > (lim - wsti_pkg::VALUE_W'(d)) / wsti_pkg::VALUE_W'(ps_base))
        begin
            ps_ovf = 1'b1;
        end else begin
            ps_acc = ps_acc * wsti_pkg::VALUE_W'(ps_base) + wsti_pkg::VALUE_W'(d);
        end
        ps_seen = 1'b1;
    endtask

    task automatic close_number(input logic [wsti_pkg::END_W-1:0] endpos);
        ps_phase     = wsti_pkg::PH_DONE;
        step_emitted = 1'b1;
        step_result  = '0;
        if (ps_seen) begin
            if (ps_ovf) begin
                step_result.value = ps_neg ? wsti_pkg::SAT_NEG_VAL : wsti_pkg::SAT_POS_VAL;
            end else begin
                step_result.value = ps_neg ? -ps_acc : ps_acc;
            end
            step_result.oor     = ps_ovf;
            step_result.end_off = endpos;
        end
    endtask

    task automatic try_digit(input logic [wsti_pkg::CHAR_W-1:0] c);
        logic [6:0] d;
        d = char_digit(c);
        if (ps_base < wsti_pkg::BASE_MIN || ps_base > wsti_pkg::BASE_MAX || d >= 7'(ps_base))
        begin
            close_number(ps_pos);
        end else begin
            add_digit(d);
            ps_phase = wsti_pkg::PH_DIGITS;
        end
    endtask

    task automatic open_number(input logic [wsti_pkg::CHAR_W-1:0] c);
        ps_base = cfg_base;
        if ((ps_base == wsti_pkg::BASE_AUTO || ps_base == wsti_pkg::BASE_HEX) &&
            c == wsti_pkg::CH_ZERO) begin
            ps_seen  = 1'b1;
            ps_acc   = '0;
            ps_phase = wsti_pkg::PH_ZERO;
        end else begin
            if (ps_base == wsti_pkg::BASE_AUTO) ps_base = wsti_pkg::BASE_DEC;
            try_digit(c);
        end
    endtask

    task automatic advance_parse(input logic [wsti_pkg::CHAR_W-1:0] c, input logic start);
        logic [6:0] d;
        step_emitted = 1'b0;
        if (start) clear_parse();
        case (ps_phase)
            wsti_pkg::PH_SPACE: begin
                if (c == wsti_pkg::CH_SPACE || (c >= wsti_pkg::CH_TAB && c <= wsti_pkg::CH_CR))
                begin
                end else if (c == wsti_pkg::CH_MINUS) begin
                    ps_neg   = 1'b1;
                    ps_phase = wsti_pkg::PH_SIGNED;
                end else if (c == wsti_pkg::CH_PLUS) begin
                    ps_phase = wsti_pkg::PH_SIGNED;
                end else begin
                    open_number(c);
                end
            end
            wsti_pkg::PH_SIGNED: open_number(c);
            wsti_pkg::PH_ZERO: begin
                if (c == wsti_pkg::CH_LOW_X || c == wsti_pkg::CH_UP_X) begin
                    ps_phase = wsti_pkg::PH_PREFIX;
                end else begin
                    if (ps_base == wsti_pkg::BASE_AUTO) ps_base = wsti_pkg::BASE_OCT;
                    try_digit(c);
                end
            end
            wsti_pkg::PH_PREFIX: begin
                d = char_digit(c);
                if (d < 7'd16) begin
                    ps_base = wsti_pkg::BASE_HEX;
                    add_digit(d);
                    ps_phase = wsti_pkg::PH_DIGITS;
                end else begin
                    close_number(ps_pos > 0 ? ps_pos - 1'b1 : '0);
                end
            end
            wsti_pkg::PH_DIGITS: try_digit(c);
            default: begin
            end
        endcase
        if (32'(ps_pos) < wsti_pkg::MAX_LENGTH_DEF) ps_pos = ps_pos + 1'b1;
    endtask

    // One beat on s_axis; called and returning at a falling edge.
    task automatic send_char(input logic [wsti_pkg::CHAR_W-1:0] code, input logic start,
                             input logic counted, input logic typed, input t_int_result want);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3))
                @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b000, code};
        s_axis_tuser  = start;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_parse(code, start);
        if (typed) begin
            pending_results.push_back(want);
        end else if (step_emitted) begin
            pending_results.push_back(step_result);
        end
        if (counted) chars_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic write_base(input logic [wsti_pkg::BASE_W-1:0] b);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = b;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_base = b;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_cfg(input logic [wsti_pkg::BASE_W-1:0] b);
        t_dir_row r;
        r       = '{kind: ROW_CFG, default: '0};
        r.code  = wsti_pkg::CHAR_W'(b);
        dir_rows.push_back(r);
    endtask

    task automatic add_run(input logic [wsti_pkg::CHAR_W-1:0] code, input logic start,
                           input int reps);
        t_dir_row r;
        r       = '{kind: ROW_CHARS, default: '0};
        r.code  = code;
        r.start = start;
        r.reps  = reps;
        dir_rows.push_back(r);
    endtask

    task automatic add_end(input logic [wsti_pkg::CHAR_W-1:0] code, input logic start,
                           input logic [wsti_pkg::VALUE_W-1:0] value, input logic oor,
                           input logic [wsti_pkg::END_W-1:0] end_off);
        t_dir_row r;
        r         = '{kind: ROW_CHARS, default: '0};
        r.code    = code;
        r.start   = start;
        r.reps    = 1;
        r.typed   = 1'b1;
        r.want    = {value, oor, end_off};
        dir_rows.push_back(r);
    endtask

    function automatic logic [wsti_pkg::CHAR_W-1:0] digit_char(input int d);
        if (d < 10) return wsti_pkg::CH_ZERO + wsti_pkg::CHAR_W'(d);
        return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + wsti_pkg::CHAR_W'(d - 10);
    endfunction

    function automatic logic [wsti_pkg::CHAR_W-1:0] junk_char();
        case ($urandom_range(0, 3))
            0: return CH_NUL;
            1: return wsti_pkg::CHAR_W'($urandom_range(0, 127));
            2: return wsti_pkg::CHAR_W'($urandom_range(0, 1114111));
            default: return CH_BANG + wsti_pkg::CHAR_W'($urandom_range(0, 14));
        endcase
    endfunction

    task automatic send_string(input logic [wsti_pkg::BASE_W-1:0] b);
        t_int_result none;
        int          n;
        int          db;
        int          i;
        logic        first;
        logic        hex_pfx;
        logic        oct_pfx;
        none  = '0;
        first = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
                send_char(junk_char(), (i == 0) ? first : ($urandom_range(0, 7) == 0),
                          1'b1, 1'b0, none);
            end
        end else begin
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            for (i = 0; i < n; i++) begin
                send_char(($urandom_range(0, 1) ? wsti_pkg::CH_SPACE
                           : wsti_pkg::CH_TAB + wsti_pkg::CHAR_W'($urandom_range(0, 4))),
                          first, 1'b1, 1'b0, none);
                first = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: begin
                    send_char(wsti_pkg::CH_MINUS, first, 1'b1, 1'b0, none);
                    first = 1'b0;
                end
                1: begin
                    send_char(wsti_pkg::CH_PLUS, first, 1'b1, 1'b0, none);
                    first = 1'b0;
                end
                default: begin
                end
            endcase
            hex_pfx = (b == wsti_pkg::BASE_AUTO || b == wsti_pkg::BASE_HEX) &&
                      ($urandom_range(0, 2) == 0);
            oct_pfx = !hex_pfx && b == wsti_pkg::BASE_AUTO && $urandom_range(0, 1);
            if (hex_pfx || oct_pfx) begin
                send_char(wsti_pkg::CH_ZERO, first, 1'b1, 1'b0, none);
                first = 1'b0;
            end
            if (hex_pfx) send_char($urandom_range(0, 1) ? wsti_pkg::CH_LOW_X : wsti_pkg::CH_UP_X,
                                   1'b0, 1'b1, 1'b0, none);
            if (hex_pfx || b == wsti_pkg::BASE_HEX) db = 16;
            else if (oct_pfx) db = 8;
            else if (b >= wsti_pkg::BASE_MIN && b <= wsti_pkg::BASE_MAX) db = int'(b);
            else db = 10;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
            for (i = 0; i < n; i++) begin
                send_char(digit_char(($urandom_range(0, 15) == 0) ? $urandom_range(0, 35)
                                                                  : $urandom_range(0, db - 1)),
                          first, 1'b1, 1'b0, none);
                first = 1'b0;
            end
            send_char(($urandom_range(0, 4) == 0) ? digit_char($urandom_range(0, 35))
                                                  : junk_char(),
                      first, 1'b1, 1'b0, none);
        end
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) send_char(junk_char(), 1'b0, 1'b0, 1'b0, none);
    endtask

    // receiver: switches between random stall patterns (open, busy, sparse, toggle); long hold on request
    initial begin : rx_stall
        t_rx_mode mode;
        int       span;
        int       k;
        m_axis_tready = 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                if (hold_asks != hold_done) begin
                    m_axis_tready = 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                    hold_done++;
                end else begin
                    case (mode)
                        RX_OPEN:   m_axis_tready = 1'b1;
                        RX_BUSY:   m_axis_tready = ($urandom_range(0, 3) != 0);
                        RX_SPARSE: m_axis_tready = ($urandom_range(0, 3) == 0);
                        default:   m_axis_tready = k[2];
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_int_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got value %h oor %0d end %0d",
                         $time, m_axis_tdata[63:0], m_axis_tuser[0], m_axis_tdata[79:64]);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[63:0] !== want.value) begin
                    $display("%0t: value mismatch: expected %h, got %h",
                             $time, want.value, m_axis_tdata[63:0]);
                    n_errors++;
                end
                if (m_axis_tuser[0] !== want.oor) begin
                    $display("%0t: out_of_range mismatch: expected %0d, got %0d",
                             $time, want.oor, m_axis_tuser[0]);
                    n_errors++;
                end
                if (m_axis_tdata[79:64] !== want.end_off) begin
                    $display("%0t: end_offset mismatch: expected %0d, got %0d",
                             $time, want.end_off, m_axis_tdata[79:64]);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic [wsti_pkg::BASE_W-1:0] base_plan[8];
        logic [wsti_pkg::BASE_W-1:0] b;
        t_int_result                 none;
        int                          ph;
        int                          goal;
        int                          r;
        int                          k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        n_errors      = 0;
        chars_sent    = 0;
        burst_left    = 0;
        hold_asks     = 0;
        hold_done     = 0;
        none          = '0;
        cfg_base      = wsti_pkg::BASE_DEC;
        clear_parse();
        base_plan = '{wsti_pkg::BASE_AUTO, wsti_pkg::BASE_HEX, wsti_pkg::BASE_DEC,
                      wsti_pkg::BASE_MIN, wsti_pkg::BASE_MAX, wsti_pkg::BASE_OCT,
                      BASE_ONE, BASE_BAD};

        // no start flag after reset, white space and sign
        add_run(wsti_pkg::CH_SPACE, 1'b0, 1);
        add_run(wsti_pkg::CH_MINUS, 1'b0, 1);
        add_run(wsti_pkg::CH_ZERO + 21'd9, 1'b0, 1);
        add_end(CH_NUL, 1'b0, -64'sd9, 1'b0, 16'd3);
        // sign twice
        add_run(wsti_pkg::CH_PLUS, 1'b1, 1);
        add_end(wsti_pkg::CH_PLUS, 1'b0, '0, 1'b0, '0);
        // space after sign
        add_run(wsti_pkg::CH_TAB, 1'b1, 1);
        add_run(wsti_pkg::CH_CR, 1'b0, 1);
        add_run(wsti_pkg::CH_MINUS, 1'b0, 1);
        add_end(wsti_pkg::CH_SPACE, 1'b0, '0, 1'b0, '0);
        // hex: bare prefix, then full prefix ended by the top code point
        add_cfg(wsti_pkg::BASE_HEX);
        add_run(wsti_pkg::CH_ZERO, 1'b1, 1);
        add_run(wsti_pkg::CH_LOW_X, 1'b0, 1);
        add_end(CH_LOW_A + 21'd6, 1'b0, '0, 1'b0, 16'd1);
        add_run(wsti_pkg::CH_ZERO, 1'b1, 1);
        add_run(wsti_pkg::CH_UP_X, 1'b0, 1);
        add_run(CH_LOW_A + 21'd5, 1'b0, 1);
        add_run(CH_UP_A + 21'd5, 1'b0, 1);
        add_run(CH_TOP, 1'b0, 1);
        // auto base picks octal
        add_cfg(wsti_pkg::BASE_AUTO);
        add_run(wsti_pkg::CH_ZERO, 1'b1, 1);
        add_run(wsti_pkg::CH_ZERO + 21'd7, 1'b0, 2);
        add_run(CH_NUL, 1'b0, 1);
        // saturation both ways
        add_cfg(wsti_pkg::BASE_MAX);
        add_run(CH_LOW_A + 21'd25, 1'b1, 16);
        add_end(CH_BANG, 1'b0, wsti_pkg::SAT_POS_VAL, 1'b1, 16'd16);
        add_run(wsti_pkg::CH_MINUS, 1'b1, 1);
        add_run(CH_UP_A + 21'd25, 1'b0, 16);
        add_end(CH_NUL, 1'b0, wsti_pkg::SAT_NEG_VAL, 1'b1, 16'd17);
        // bases that accept no digit, then base 2 ended by the digit 2
        add_cfg(BASE_ONE);
        add_end(wsti_pkg::CH_ZERO + 21'd5, 1'b1, '0, 1'b0, '0);
        add_cfg(BASE_BAD);
        add_run(wsti_pkg::CH_MINUS, 1'b1, 1);
        add_end(wsti_pkg::CH_ZERO + 21'd1, 1'b0, '0, 1'b0, '0);
        add_cfg(wsti_pkg::BASE_MIN);
        add_run(wsti_pkg::CH_ZERO + 21'd1, 1'b1, 2);
        add_run(wsti_pkg::CH_ZERO + 21'd2, 1'b0, 1);
        add_run(wsti_pkg::CH_ZERO + 21'd1, 1'b0, 1);
        // long strings
        add_cfg(wsti_pkg::BASE_DEC);
        add_run(wsti_pkg::CH_SPACE, 1'b1, LONG_RUN);
        add_run(wsti_pkg::CH_ZERO + 21'd7, 1'b0, 1);
        add_run(CH_NUL, 1'b0, 1);
        add_cfg(wsti_pkg::BASE_HEX);
        add_run(wsti_pkg::CH_SPACE, 1'b1, LONG_RUN);
        add_run(wsti_pkg::CH_ZERO, 1'b0, 1);
        add_run(wsti_pkg::CH_LOW_X, 1'b0, 1);
        add_run(CH_LOW_A + 21'd16, 1'b0, 1);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < dir_rows.size(); r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_base(wsti_pkg::BASE_W'(dir_rows[r].code));
            end else begin
                for (k = 0; k < dir_rows[r].reps; k++) begin
                    send_char(dir_rows[r].code, dir_rows[r].start && k == 0, 1'b1,
                              dir_rows[r].typed && k == dir_rows[r].reps - 1,
                              dir_rows[r].want);
                end
            end
        end

        goal = chars_sent + RAND_ITEMS;
        ph   = 0;
        while (chars_sent < goal) begin
            if (ph < 8) b = base_plan[ph];
            else if ($urandom_range(0, 3) != 0) b = wsti_pkg::BASE_W'($urandom_range(2, 36));
            else b = wsti_pkg::BASE_W'($urandom_range(0, 63));
            write_base(b);
            if (ph == 2 || ph == 6) hold_asks++;
            k = chars_sent + PHASE_ITEMS;
            while (chars_sent < k && chars_sent < goal) send_string(b);
            ph++;
        end

        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
